// ===== design/gn3_pkg.sv =====
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared widths, gradient select codes and the permutation table for the
// 3-D gradient noise pipeline.
// ----------------------------------------------------------------------------
package gn3_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int COORD_W           = 24;
   localparam int REQ_TDATA_W       = 3 * COORD_W;
   localparam int NOISE_W           = 18;
   localparam int RSP_TDATA_W       = ((NOISE_W + 7) / 8) * 8;
   localparam int NOISE_FB          = 16;
   localparam int NOISE_SAT         = 65536;
   localparam int CELL_W            = 8;
   localparam int HASH_W            = 4;
   localparam int CORNERS           = 8;
   localparam int AXES              = 3;

   // fade polynomial 6t^5 - 15t^4 + 10t^3
   localparam int FADE_K5 = 6;
   localparam int FADE_K4 = 15;
   localparam int FADE_K3 = 10;

   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [HASH_W-1:0] hash_type;

   // gradient select codes on the low hash bits
   localparam hash_type GRAD_U_FROM_Y = 4'd8;   // at or above: u takes y
   localparam hash_type GRAD_V_FROM_Y = 4'd4;   // below: v takes y
   localparam hash_type GRAD_V_X_LO   = 4'd12;  // v takes x
   localparam hash_type GRAD_V_X_HI   = 4'd14;  // v takes x

   localparam cell_type PERM_TABLE [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   function automatic cell_type perm(input cell_type idx);
      return PERM_TABLE[idx];
   endfunction

endpackage

// ===== design/gn3_fade.sv =====
// ----------------------------------------------------------------------------
// gn3_fade
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 on one axis fraction,
// one multiply level per stage, products floored.
// ----------------------------------------------------------------------------
module gn3_fade #(
   parameter int FRAC_BITS = gn3_pkg::FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic [2:0]           stage_en,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   fade
);
   import gn3_pkg::*;

   localparam int FB   = FRAC_BITS;
   localparam int M_W  = FB + 5;
   localparam int SQ_W = 2 * FB;
   localparam int QP_W = 2 * FB + 6;

   logic [SQ_W-1:0]        sq_full;
   logic signed [M_W-1:0]  slope;
   logic signed [QP_W-1:0] qp;
   logic [FB-1:0]          t1_ff, sq1_ff, sq1_in;
   logic signed [M_W-1:0]  q1_ff, q1_in;

   logic [SQ_W-1:0]        cube_full;
   logic [FB-1:0]          cube_ff, cube_in;
   logic signed [M_W-1:0]  inner_ff, inner_in;

   logic signed [QP_W-1:0] fp;
   logic [FB:0]            fade_ff, fade_in;

   always_comb begin
      // stage 1: t^2 and t*(6t - 15)
      sq_full = SQ_W'(frac) * SQ_W'(frac);
      sq1_in  = sq_full[SQ_W-1:FB];
      slope   = M_W'(FADE_K5) * M_W'(frac) - (M_W'(FADE_K4) << FB);
      qp      = QP_W'(signed'({1'b0, frac})) * QP_W'(slope);
      q1_in   = M_W'(qp >>> FB);
      // stage 2: t^3 and the inner term
      cube_full = SQ_W'(sq1_ff) * SQ_W'(t1_ff);
      cube_in   = cube_full[SQ_W-1:FB];
      inner_in  = q1_ff + (M_W'(FADE_K3) << FB);
      // stage 3: t^3 * inner, never negative
      fp      = QP_W'(signed'({1'b0, cube_ff})) * QP_W'(inner_ff);
      fade_in = (FB + 1)'(fp >>> FB);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         t1_ff  <= frac;
         sq1_ff <= sq1_in;
         q1_ff  <= q1_in;
      end
      if (stage_en[1]) begin
         cube_ff  <= cube_in;
         inner_ff <= inner_in;
      end
      if (stage_en[2]) begin
         fade_ff <= fade_in;
      end
   end

   assign fade = fade_ff;

endmodule

// ===== design/gn3_hash.sv =====
// ----------------------------------------------------------------------------
// gn3_hash
// Corner hashing through the permutation table: one table level per stage,
// all index arithmetic wraps at 8 bits.
// ----------------------------------------------------------------------------
module gn3_hash (
   input  logic              clock,
   input  logic [2:0]        stage_en,
   input  gn3_pkg::cell_type cell_x,
   input  gn3_pkg::cell_type cell_y,
   input  gn3_pkg::cell_type cell_z,
   output gn3_pkg::hash_type corner_hash [gn3_pkg::CORNERS]
);
   import gn3_pkg::*;

   cell_type a_ff, a_in, b_ff, b_in, z_ff;
   cell_type aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   hash_type hash_ff [CORNERS];
   hash_type hash_in [CORNERS];

   always_comb begin
      a_in = perm(cell_x) + cell_y;
      b_in = perm(cell_x + CELL_W'(1)) + cell_y;

      aa_in = perm(a_ff) + z_ff;
      ab_in = perm(a_ff + CELL_W'(1)) + z_ff;
      ba_in = perm(b_ff) + z_ff;
      bb_in = perm(b_ff + CELL_W'(1)) + z_ff;

      // corner index bit 0 = x+1, bit 1 = y+1, bit 2 = z+1
      hash_in[0] = HASH_W'(perm(aa_ff));
      hash_in[1] = HASH_W'(perm(ba_ff));
      hash_in[2] = HASH_W'(perm(ab_ff));
      hash_in[3] = HASH_W'(perm(bb_ff));
      hash_in[4] = HASH_W'(perm(aa_ff + CELL_W'(1)));
      hash_in[5] = HASH_W'(perm(ba_ff + CELL_W'(1)));
      hash_in[6] = HASH_W'(perm(ab_ff + CELL_W'(1)));
      hash_in[7] = HASH_W'(perm(bb_ff + CELL_W'(1)));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_ff <= a_in;
         b_ff <= b_in;
         z_ff <= cell_z;
      end
      if (stage_en[1]) begin
         aa_ff <= aa_in;
         ab_ff <= ab_in;
         ba_ff <= ba_in;
         bb_ff <= bb_in;
      end
      if (stage_en[2]) begin
         hash_ff <= hash_in;
      end
   end

   assign corner_hash = hash_ff;

endmodule

// ===== design/gn3_lerp.sv =====
// ----------------------------------------------------------------------------
// gn3_lerp
// One level of linear blends, lo + floor(t * (hi - lo)), across LANES lanes.
// Stage A multiplies, stage B shifts and adds.
// ----------------------------------------------------------------------------
module gn3_lerp #(
   parameter int LANES     = 4,
   parameter int FRAC_BITS = gn3_pkg::FRACTION_BITS_DEF,
   parameter int VAL_W     = gn3_pkg::FRACTION_BITS_DEF + 4
) (
   input  logic                    clock,
   input  logic [1:0]              stage_en,
   input  logic [FRAC_BITS:0]      weight,
   input  logic signed [VAL_W-1:0] val_lo [LANES],
   input  logic signed [VAL_W-1:0] val_hi [LANES],
   output logic signed [VAL_W-1:0] mix    [LANES]
);

   localparam int PROD_W = FRAC_BITS + VAL_W + 3;

   logic signed [FRAC_BITS+1:0] weight_s;
   logic signed [VAL_W-1:0]     base_ff [LANES];
   logic signed [PROD_W-1:0]    prod_ff [LANES];
   logic signed [PROD_W-1:0]    prod_in [LANES];
   logic signed [VAL_W-1:0]     mix_ff  [LANES];
   logic signed [VAL_W-1:0]     mix_in  [LANES];

   always_comb begin
      weight_s = {1'b0, weight};
      for (int i = 0; i < LANES; i++) begin
         prod_in[i] = PROD_W'(weight_s) * (PROD_W'(val_hi[i]) - PROD_W'(val_lo[i]));
         mix_in[i]  = base_ff[i] + VAL_W'(prod_ff[i] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         base_ff <= val_lo;
         prod_ff <= prod_in;
      end
      if (stage_en[1]) begin
         mix_ff <= mix_in;
      end
   end

   assign mix = mix_ff;

endmodule

// ===== design/gradient_noise_3d.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved Perlin gradient noise in three dimensions, fixed point.
// ----------------------------------------------------------------------------
// Takes one word of x, y, z coordinates (unsigned, FRACTION_BITS fraction
// bits, integer part wrapping modulo 256) per clock and returns the noise
// value as signed 2.16, clamped to plus or minus one. The pipeline is 11
// register stages deep: three for the table hashing and fade curves (run
// side by side), one for the corner gradients, two per blend level over
// three levels, and one for scaling and clamping. Throughput is one word per
// cycle while the output side does not stall. Every stage has its own
// enable, so bubbles close up and a word can be accepted while a finished
// result still waits at the output.
module gradient_noise_3d #(
   parameter int FRACTION_BITS = gn3_pkg::FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [23:0] coord_x, [47:24] coord_y, [71:48] coord_z
   input  logic [gn3_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [17:0] noise_value, [23:18] zero
   output logic [gn3_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import gn3_pkg::*;

   localparam int FB  = FRACTION_BITS;
   localparam int VW  = FB + 4;
   localparam int NS  = 11;
   localparam int SHL = (FB < NOISE_FB) ? NOISE_FB - FB : 0;
   localparam int SHR = (FB > NOISE_FB) ? FB - NOISE_FB : 0;
   localparam int OW  = VW + SHL;
   localparam logic signed [VW-1:0] ONE_V   = VW'(1) << FB;
   localparam logic signed [OW-1:0] SAT_POS = OW'(NOISE_SAT);
   localparam logic signed [OW-1:0] SAT_NEG = -SAT_POS;

   // pipeline control
   logic [NS:1] vld_ff, vld_in;
   logic [NS:1] stage_en;
   logic        in_acc, out_acc;

   // stage 1 inputs and fraction delay
   logic [COORD_W-1:0] coord    [AXES];
   logic [COORD_W-1:0] cell_sh  [AXES];
   cell_type           cell_idx [AXES];
   logic [FB-1:0]      frac_in  [AXES];
   logic [FB-1:0]      frac_ff  [1:3][AXES];

   logic [FB:0]        fade_s3 [AXES];
   hash_type           corner_hash [CORNERS];

   // stage 4
   logic [2:0]              kb;
   logic signed [VW-1:0]    gx, gy, gz;
   logic signed [VW-1:0]    grad_ff [CORNERS];
   logic signed [VW-1:0]    grad_in [CORNERS];
   logic [FB:0]             u_ff;
   logic [FB:0]             v_ff [4:6];
   logic [FB:0]             w_ff [4:8];

   // blend tree
   logic signed [VW-1:0] lo1 [4], hi1 [4], mix1 [4];
   logic signed [VW-1:0] lo2 [2], hi2 [2], mix2 [2];
   logic signed [VW-1:0] lo3 [1], hi3 [1], mix3 [1];

   // output stage
   logic signed [OW-1:0]  r_ext, scaled, clamped;
   logic [NOISE_W-1:0]    noise_ff, noise_in;

   function automatic logic signed [VW-1:0] corner_grad(
      input hash_type             h,
      input logic signed [VW-1:0] cx,
      input logic signed [VW-1:0] cy,
      input logic signed [VW-1:0] cz
   );
      logic signed [VW-1:0] gu, gv;
      gu = (h < GRAD_U_FROM_Y) ? cx : cy;
      if (h < GRAD_V_FROM_Y) begin
         gv = cy;
      end else if (h == GRAD_V_X_LO || h == GRAD_V_X_HI) begin
         gv = cx;
      end else begin
         gv = cz;
      end
      return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
   endfunction

   // ---- handshake and per-stage enables ----
   always_comb begin
      stage_en[NS] = !vld_ff[NS] || rsp_tready;
      for (int k = NS - 1; k >= 1; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in[1] = stage_en[1] ? req_tvalid : vld_ff[1];
      for (int k = 2; k <= NS; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_tready = stage_en[1] && !reset;
   assign rsp_tvalid = vld_ff[NS];
   assign in_acc     = req_tvalid && req_tready;
   assign out_acc    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---- coordinate split ----
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         coord[a]    = req_tdata[a*COORD_W +: COORD_W];
         cell_sh[a]  = coord[a] >> FB;
         cell_idx[a] = cell_sh[a][CELL_W-1:0];
         frac_in[a]  = coord[a][FB-1:0];
      end
   end

   gn3_hash u_hash (
      .clock       (clock),
      .stage_en    (stage_en[3:1]),
      .cell_x      (cell_idx[0]),
      .cell_y      (cell_idx[1]),
      .cell_z      (cell_idx[2]),
      .corner_hash (corner_hash)
   );

   for (genvar a = 0; a < AXES; a++) begin : g_fade
      gn3_fade #(
         .FRAC_BITS (FB)
      ) u_fade (
         .clock    (clock),
         .stage_en (stage_en[3:1]),
         .frac     (frac_in[a]),
         .fade     (fade_s3[a])
      );
   end

   // ---- corner gradients ----
   always_comb begin
      kb = '0;
      gx = '0;
      gy = '0;
      gz = '0;
      for (int k = 0; k < CORNERS; k++) begin
         kb = 3'(k);
         gx = VW'(frac_ff[3][0]) - (kb[0] ? ONE_V : '0);
         gy = VW'(frac_ff[3][1]) - (kb[1] ? ONE_V : '0);
         gz = VW'(frac_ff[3][2]) - (kb[2] ? ONE_V : '0);
         grad_in[k] = corner_grad(corner_hash[k], gx, gy, gz);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         frac_ff[1] <= frac_in;
      end
      for (int k = 2; k <= 3; k++) begin
         if (stage_en[k]) begin
            frac_ff[k] <= frac_ff[k-1];
         end
      end
      if (stage_en[4]) begin
         grad_ff <= grad_in;
         u_ff    <= fade_s3[0];
         v_ff[4] <= fade_s3[1];
         w_ff[4] <= fade_s3[2];
      end
      for (int k = 5; k <= 6; k++) begin
         if (stage_en[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
      for (int k = 5; k <= 8; k++) begin
         if (stage_en[k]) begin
            w_ff[k] <= w_ff[k-1];
         end
      end
      if (stage_en[NS]) begin
         noise_ff <= noise_in;
      end
   end

   // ---- blend tree: x, then y, then z ----
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lo1[i] = grad_ff[2*i];
         hi1[i] = grad_ff[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         lo2[i] = mix1[2*i];
         hi2[i] = mix1[2*i+1];
      end
      lo3[0] = mix2[0];
      hi3[0] = mix2[1];
   end

   gn3_lerp #(
      .LANES (4), .FRAC_BITS (FB), .VAL_W (VW)
   ) u_lerp_x (
      .clock (clock), .stage_en (stage_en[6:5]), .weight (u_ff),
      .val_lo (lo1), .val_hi (hi1), .mix (mix1)
   );

   gn3_lerp #(
      .LANES (2), .FRAC_BITS (FB), .VAL_W (VW)
   ) u_lerp_y (
      .clock (clock), .stage_en (stage_en[8:7]), .weight (v_ff[6]),
      .val_lo (lo2), .val_hi (hi2), .mix (mix2)
   );

   gn3_lerp #(
      .LANES (1), .FRAC_BITS (FB), .VAL_W (VW)
   ) u_lerp_z (
      .clock (clock), .stage_en (stage_en[10:9]), .weight (w_ff[8]),
      .val_lo (lo3), .val_hi (hi3), .mix (mix3)
   );

   // ---- rescale to 16 fraction bits and clamp ----
   always_comb begin
      r_ext  = OW'(mix3[0]);
      scaled = (r_ext <<< SHL) >>> SHR;
      if (scaled > SAT_POS) begin
         clamped = SAT_POS;
      end else if (scaled < SAT_NEG) begin
         clamped = SAT_NEG;
      end else begin
         clamped = scaled;
      end
      noise_in = NOISE_W'(clamped);
   end

   assign rsp_tdata = RSP_TDATA_W'(noise_ff);

   // ---- checks ----
   a_noise_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(noise_ff) <= NOISE_SAT && $signed(noise_ff) >= -NOISE_SAT))
      else $error("noise word outside clamp range");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline full and stalled");

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(vld_ff) ==
         $past($countones(vld_ff)) + $past(in_acc) - $past(out_acc))
      else $error("word lost or duplicated in pipeline");

endmodule
